### rtl/b32m_pkg.sv
package b32m_pkg;

	localparam int HRP_TEXT_W = 64;
	localparam int HRP_LEN_W  = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CHK_W      = 30;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_HRP_TEXT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HRP_LENGTH = 1'b1;

	localparam logic [HRP_TEXT_W-1:0] HRP_TEXT_RST = 64'd28787;
	localparam logic [HRP_LEN_W-1:0]  HRP_LEN_RST  = 4'd2;

	localparam logic [CHK_W-1:0] CHK_INIT    = 30'd1;
	localparam logic [CHK_W-1:0] BECH32M_XOR = 30'h2bc830a3;
	localparam logic [2:0]       CSUM_LAST   = 3'd5;
	localparam logic [6:0]       SEP_CHAR    = 7'h31;

	localparam logic [4:0][CHK_W-1:0] GEN = {
		30'h2a1462b3, 30'h3d4233dd, 30'h1ea119fa, 30'h26508e6d, 30'h3b6a57b2
	};

	localparam logic [32*8-1:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_HI,
		OP_ZERO,
		OP_LO,
		OP_SEP,
		OP_VER,
		OP_GRP,
		OP_PAD,
		OP_CSUM
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       first;
		logic [2:0] idx;
		logic       last_char;
	} cmd_t;

	typedef struct packed {
		logic                 out_free;
		logic                 grp_two;
		logic                 pad_need;
		logic [HRP_LEN_W-1:0] hrp_len;
	} sts_t;

	function automatic logic [CHK_W-1:0] poly_step(input logic [CHK_W-1:0] c,
			input logic [4:0] v);
		logic [4:0]       top;
		logic [CHK_W-1:0] n;
		top = c[29:25];
		n   = {c[24:0], 5'b0} ^ {25'b0, v};
		for (int k = 0; k < 5; k++) begin
			if (top[k]) begin
				n = n ^ GEN[k];
			end
		end
		return n;
	endfunction

	function automatic logic [6:0] letter(input logic [4:0] g);
		logic [7:0] c;
		c = CHARSET[(5'd31 - g)*8 +: 8];
		return c[6:0];
	endfunction

endpackage

### rtl/b32m_in_if.sv
interface b32m_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, output payload_byte, output first_byte,
		output last_byte, input ready);
	modport sink (input valid, input payload_byte, input first_byte,
		input last_byte, output ready);
endinterface

### rtl/b32m_out_if.sv
interface b32m_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface

### rtl/b32m_cfg_if.sv
interface b32m_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [b32m_pkg::CFG_IDX_W-1:0]      index;
	logic [b32m_pkg::HRP_TEXT_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/b32m_dpath.sv
module b32m_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  b32m_pkg::cmd_t                    cmd,
	output b32m_pkg::sts_t                    sts,
	input  logic [7:0]                        payload_byte,
	input  logic                              cfg_valid,
	input  logic [b32m_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [b32m_pkg::HRP_TEXT_W-1:0]   cfg_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [6:0]                        out_char,
	output logic                              last_char
);

	logic [b32m_pkg::HRP_TEXT_W-1:0] hrp_text_q;
	logic [b32m_pkg::HRP_LEN_W-1:0]  hrp_len_q;
	logic [b32m_pkg::CHK_W-1:0]      chk_q;
	logic [11:0]                     acc_q;
	logic [3:0]                      bits_q;
	logic                            out_valid_q;
	logic [6:0]                      out_char_q;
	logic                            last_char_q;

	logic [7:0]                 hrp_char;
	logic [3:0]                 lo_mask;
	logic [3:0]                 lo_bits;
	logic [3:0]                 grp_sh;
	logic [4:0]                 g_grp;
	logic [4:0]                 g_pad;
	logic [4:0]                 g_csum;
	logic [b32m_pkg::CHK_W-1:0] fin;
	logic [4:0]                 step_val;
	logic                       do_step;
	logic                       emit;
	logic [6:0]                 emit_char;

	assign hrp_char = hrp_text_q[8*cmd.idx +: 8];
	assign lo_mask  = 4'((5'd1 << bits_q[2:0]) - 5'd1);
	assign lo_bits  = acc_q[3:0] & lo_mask;
	assign grp_sh   = bits_q - 4'd5;
	assign g_grp    = 5'(acc_q >> grp_sh);
	assign g_pad    = 5'({1'b0, lo_bits} << (3'd5 - bits_q[2:0]));
	assign fin      = chk_q ^ b32m_pkg::BECH32M_XOR;

	always_comb begin
		case (cmd.idx)
			3'd0:    g_csum = fin[29:25];
			3'd1:    g_csum = fin[24:20];
			3'd2:    g_csum = fin[19:15];
			3'd3:    g_csum = fin[14:10];
			3'd4:    g_csum = fin[9:5];
			default: g_csum = fin[4:0];
		endcase
	end

	always_comb begin
		step_val  = 5'd0;
		do_step   = 1'b0;
		emit      = 1'b0;
		emit_char = 7'd0;
		unique case (cmd.op)
			b32m_pkg::OP_HI: begin
				do_step  = 1'b1;
				step_val = {2'b0, hrp_char[7:5]};
			end
			b32m_pkg::OP_ZERO: begin
				do_step = 1'b1;
			end
			b32m_pkg::OP_LO: begin
				do_step   = 1'b1;
				step_val  = hrp_char[4:0];
				emit      = 1'b1;
				emit_char = hrp_char[6:0];
			end
			b32m_pkg::OP_SEP: begin
				emit      = 1'b1;
				emit_char = b32m_pkg::SEP_CHAR;
			end
			b32m_pkg::OP_VER: begin
				do_step   = 1'b1;
				emit      = 1'b1;
				emit_char = b32m_pkg::letter(5'd0);
			end
			b32m_pkg::OP_GRP: begin
				do_step   = 1'b1;
				step_val  = g_grp;
				emit      = 1'b1;
				emit_char = b32m_pkg::letter(g_grp);
			end
			b32m_pkg::OP_PAD: begin
				do_step   = 1'b1;
				step_val  = g_pad;
				emit      = 1'b1;
				emit_char = b32m_pkg::letter(g_pad);
			end
			b32m_pkg::OP_CSUM: begin
				emit      = 1'b1;
				emit_char = b32m_pkg::letter(g_csum);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hrp_text_q  <= b32m_pkg::HRP_TEXT_RST;
			hrp_len_q   <= b32m_pkg::HRP_LEN_RST;
			chk_q       <= b32m_pkg::CHK_INIT;
			acc_q       <= 12'd0;
			bits_q      <= 4'd0;
			out_valid_q <= 1'b0;
			out_char_q  <= 7'd0;
			last_char_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					b32m_pkg::REG_HRP_TEXT:   hrp_text_q <= cfg_data;
					b32m_pkg::REG_HRP_LENGTH: hrp_len_q  <= cfg_data[3:0];
					default: begin
					end
				endcase
			end

			if (cmd.op == b32m_pkg::OP_LOAD) begin
				if (cmd.first) begin
					chk_q  <= b32m_pkg::CHK_INIT;
					acc_q  <= {4'd0, payload_byte};
					bits_q <= 4'd8;
				end else begin
					acc_q  <= {lo_bits, payload_byte};
					bits_q <= bits_q + 4'd8;
				end
			end else if (do_step) begin
				chk_q <= b32m_pkg::poly_step(chk_q, step_val);
			end

			if (cmd.op == b32m_pkg::OP_GRP) begin
				bits_q <= grp_sh;
			end

			// string closed: back to a clean running state
			if (cmd.op == b32m_pkg::OP_CSUM && cmd.last_char) begin
				chk_q  <= b32m_pkg::CHK_INIT;
				bits_q <= 4'd0;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
				out_char_q  <= emit_char;
				last_char_q <= cmd.last_char;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.grp_two  = bits_q >= 4'd10;
	assign sts.pad_need = bits_q != 4'd0;
	assign sts.hrp_len  = hrp_len_q;

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_char_q;

endmodule

### rtl/b32m_ctrl.sv
module b32m_ctrl #(
	parameter int HRP_MAX_CHARS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           first_byte,
	input  logic           last_byte,
	input  b32m_pkg::sts_t sts,
	output b32m_pkg::cmd_t cmd
);

	localparam int LEN_W = $clog2(HRP_MAX_CHARS + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_HRP_HI,
		S_HRP_ZERO,
		S_HRP_LO,
		S_SEP,
		S_VER,
		S_GRP,
		S_PAD,
		S_ZEROS,
		S_CSUM
	} state_t;

	state_t           state_q;
	logic [2:0]       cnt_q;
	logic [LEN_W-1:0] len_q;
	logic             last_q;

	logic [3:0] len_clamp;
	logic       cnt_end_hrp;
	logic       emit;

	always_comb begin
		if (sts.hrp_len == 4'd0) begin
			len_clamp = 4'd1;
		end else if (sts.hrp_len > 4'(HRP_MAX_CHARS)) begin
			len_clamp = 4'(HRP_MAX_CHARS);
		end else begin
			len_clamp = sts.hrp_len;
		end
	end

	assign cnt_end_hrp = (4'(cnt_q) + 4'd1) == 4'(len_q);
	assign in_ready    = state_q == S_IDLE;

	always_comb begin
		cmd.op        = b32m_pkg::OP_NONE;
		cmd.first     = first_byte;
		cmd.idx       = cnt_q;
		cmd.last_char = 1'b0;
		unique case (state_q)
			S_IDLE:     if (in_valid) cmd.op = b32m_pkg::OP_LOAD;
			S_HRP_HI:   cmd.op = b32m_pkg::OP_HI;
			S_HRP_ZERO: cmd.op = b32m_pkg::OP_ZERO;
			S_HRP_LO:   if (sts.out_free) cmd.op = b32m_pkg::OP_LO;
			S_SEP:      if (sts.out_free) cmd.op = b32m_pkg::OP_SEP;
			S_VER:      if (sts.out_free) cmd.op = b32m_pkg::OP_VER;
			S_GRP:      if (sts.out_free) cmd.op = b32m_pkg::OP_GRP;
			S_PAD:      if (sts.pad_need && sts.out_free) cmd.op = b32m_pkg::OP_PAD;
			S_ZEROS:    cmd.op = b32m_pkg::OP_ZERO;
			S_CSUM: begin
				if (sts.out_free) begin
					cmd.op        = b32m_pkg::OP_CSUM;
					cmd.last_char = cnt_q == b32m_pkg::CSUM_LAST;
				end
			end
			default: begin
			end
		endcase
	end

	assign emit = (cmd.op == b32m_pkg::OP_LO) || (cmd.op == b32m_pkg::OP_SEP) ||
		(cmd.op == b32m_pkg::OP_VER) || (cmd.op == b32m_pkg::OP_GRP) ||
		(cmd.op == b32m_pkg::OP_PAD) || (cmd.op == b32m_pkg::OP_CSUM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= 3'd0;
			len_q   <= LEN_W'(1);
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= last_byte;
						cnt_q  <= 3'd0;
						if (first_byte) begin
							len_q   <= LEN_W'(len_clamp);
							state_q <= S_HRP_HI;
						end else begin
							state_q <= S_GRP;
						end
					end
				end
				S_HRP_HI: begin
					if (cnt_end_hrp) begin
						cnt_q   <= 3'd0;
						state_q <= S_HRP_ZERO;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_HRP_ZERO: state_q <= S_HRP_LO;
				S_HRP_LO: begin
					if (sts.out_free) begin
						if (cnt_end_hrp) begin
							cnt_q   <= 3'd0;
							state_q <= S_SEP;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
				end
				S_SEP: if (sts.out_free) state_q <= S_VER;
				S_VER: if (sts.out_free) state_q <= S_GRP;
				S_GRP: begin
					if (sts.out_free && !sts.grp_two) begin
						state_q <= last_q ? S_PAD : S_IDLE;
					end
				end
				S_PAD: begin
					if (!sts.pad_need || sts.out_free) begin
						cnt_q   <= 3'd0;
						state_q <= S_ZEROS;
					end
				end
				S_ZEROS: begin
					if (cnt_q == b32m_pkg::CSUM_LAST) begin
						cnt_q   <= 3'd0;
						state_q <= S_CSUM;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_CSUM: begin
					if (sts.out_free) begin
						if (cnt_q == b32m_pkg::CSUM_LAST) begin
							cnt_q   <= 3'd0;
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> sts.out_free)
		else $error("character issued while output register is occupied");

	a_close_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == b32m_pkg::OP_CSUM && cmd.last_char) |=> state_q == S_IDLE)
		else $error("controller did not return to idle after final character");

	a_hrp_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HRP_HI || state_q == S_HRP_LO) |-> 4'(cnt_q) < 4'(len_q))
		else $error("prefix index beyond prefix length");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == b32m_pkg::OP_LOAD) |=> !in_ready)
		else $error("new word taken before current one finished");
`endif

endmodule

### rtl/bech32m_v0_encoder.sv
// bech32m_v0_encoder: streaming bech32m (version 0) string encoder.
// Input: a new word is taken only in the idle state, once the previous word is sequenced.
// A continuation word yields one letter per full 5-bit group; a first word adds the prefix
// steps, separator and version; a last word adds pad, six zero steps and six letters.
// The datapath does one polymod step per cycle; output stalls hold the sequence back.
// Reset: arst_n asynchronous active low; prefix registers to "sp"/2, checksum 1, no leftovers.
module bech32m_v0_encoder #(
	parameter int HRP_MAX_CHARS = 8
) (
	input logic       clk,
	input logic       arst_n,
	b32m_in_if.sink   byte_ch,
	b32m_out_if.source char_ch,
	b32m_cfg_if.sink  cfg
);

	// controller <-> datapath
	b32m_pkg::cmd_t cmd;
	b32m_pkg::sts_t sts;

	// register writes are never back-pressured
	assign cfg.ready = 1'b1;

	// sequencer: prefix, separator, version, data groups, pad, checksum
	b32m_ctrl #(
		.HRP_MAX_CHARS(HRP_MAX_CHARS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (byte_ch.valid),
		.in_ready  (byte_ch.ready),
		.first_byte(byte_ch.first_byte),
		.last_byte (byte_ch.last_byte),
		.sts       (sts),
		.cmd       (cmd)
	);

	// polymod register, bit regrouping, charset lookup and output character register
	b32m_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.payload_byte(byte_ch.payload_byte),
		.cfg_valid   (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.out_ready   (char_ch.ready),
		.out_valid   (char_ch.valid),
		.out_char    (char_ch.out_char),
		.last_char   (char_ch.last_char)
	);

endmodule

### tb/tb_bech32m_v0_encoder.sv
`timescale 1ns / 100ps

module tb_bech32m_v0_encoder;

	// Run limits. The slowest honest run is roughly 400 words at up to 18 characters
	// each, every character held back by a heavily stalling receiver. The limit sits
	// well clear of that.
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int          HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int          SETTLE_CYCLES = 40;   // longer than the prefix latency

	// Own copy of the BCH generator and the charset; entry k serves bit k of top, bit 4 listed first
	localparam logic [4:0][29:0] POLY_GEN = {
		30'h2a1462b3, 30'h3d4233dd, 30'h1ea119fa, 30'h26508e6d, 30'h3b6a57b2
	};
	localparam logic [8*32-1:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
	localparam logic [29:0]     M_CONST  = 30'h2bc830a3;

	typedef struct packed {
		logic [6:0] ch;
		logic       fin;
	} enc_char_t;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

	typedef struct {
		row_kind_e                         kind;
		logic [b32m_pkg::CFG_IDX_W-1:0]    idx;
		logic [b32m_pkg::HRP_TEXT_W-1:0]   data;
		logic [7:0]                        b;
		logic                              f;
		logic                              l;
		string                             known;   // leading characters typed in by hand
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	b32m_in_if  byte_if ();
	b32m_out_if char_if ();
	b32m_cfg_if cfg_if ();

	bech32m_v0_encoder u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_if),
		.char_ch (char_if),
		.cfg     (cfg_if)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Predictor state: prefix registers plus the running encoder state
	// ---------------------------------------------------------------------
	logic [b32m_pkg::HRP_TEXT_W-1:0] pfx_text = b32m_pkg::HRP_TEXT_RST;
	logic [b32m_pkg::HRP_LEN_W-1:0]  pfx_len  = b32m_pkg::HRP_LEN_RST;
	logic [29:0]           csum     = 30'd1;
	logic [3:0]            spare_bits = 4'd0;
	logic [2:0]            spare_cnt  = 3'd0;

	enc_char_t fresh_chars[$];   // characters of the word just accepted
	enc_char_t chars_due[$];     // characters still owed by the block

	// Test control and bookkeeping
	int          src_gap_pct    = 13;
	int          sink_stall_pct = 63;
	int          holds_asked    = 0;
	int          holds_served   = 0;
	int          hold_left      = 0;
	int          mismatches     = 0;
	int          words_sent     = 0;
	int          strings_closed = 0;
	int          chars_seen     = 0;
	int          reg_writes     = 0;
	int unsigned cycle_count    = 0;

	dir_row_t dir_rows[24];

	function automatic logic [29:0] polymod_step(input logic [29:0] c, input logic [4:0] v);
		logic [29:0] n;
		n = {c[24:0], 5'd0} ^ {25'd0, v};
		for (int k = 0; k < 5; k++) begin
			if (c[25+k]) begin
				n = n ^ POLY_GEN[k];
			end
		end
		return n;
	endfunction

	function automatic logic [6:0] charset_letter(input logic [4:0] g);
		logic [7:0] c;
		c = ALPHABET[(31 - g)*8 +: 8];
		return c[6:0];
	endfunction

	function automatic void emit(input logic [6:0] ch, input logic fin);
		enc_char_t e;
		e.ch  = ch;
		e.fin = fin;
		fresh_chars.push_back(e);
	endfunction

	// Works out the characters one word causes and advances the encoder state
	function automatic void encode_word(input logic [7:0] b, input logic f, input logic l);
		int          take;
		int          acc;
		int          nb;
		logic [7:0]  pc;
		logic [4:0]  g;
		logic [29:0] fin;
		if (f) begin
			// new string: prefix, separator, version letter; length clamped to 1..8
			take = pfx_len;
			if (take < 1) take = 1;
			if (take > 8) take = 8;
			csum       = 30'd1;
			spare_bits = 4'd0;
			spare_cnt  = 3'd0;
			for (int i = 0; i < take; i++) begin
				pc   = pfx_text[8*i +: 8];
				csum = polymod_step(csum, {2'b00, pc[7:5]});
			end
			csum = polymod_step(csum, 5'd0);
			for (int i = 0; i < take; i++) begin
				pc   = pfx_text[8*i +: 8];
				csum = polymod_step(csum, pc[4:0]);
			end
			for (int i = 0; i < take; i++) begin
				pc = pfx_text[8*i +: 8];
				emit(pc[6:0], 1'b0);
			end
			emit(b32m_pkg::SEP_CHAR, 1'b0);
			csum = polymod_step(csum, 5'd0);
			emit(charset_letter(5'd0), 1'b0);
		end
		// 8 to 5 regrouping, MSB first
		nb  = (spare_cnt > 3'd4) ? 4 : int'(spare_cnt);
		acc = (int'(spare_bits) << 8) | int'(b);
		nb  = nb + 8;
		while (nb >= 5) begin
			nb   = nb - 5;
			g    = 5'(acc >> nb);
			csum = polymod_step(csum, g);
			emit(charset_letter(g), 1'b0);
		end
		spare_cnt  = 3'(nb);
		spare_bits = 4'(acc & ((1 << nb) - 1));
		if (l) begin
			if (spare_cnt != 3'd0) begin
				g    = 5'(int'(spare_bits) << (5 - int'(spare_cnt)));
				csum = polymod_step(csum, g);
				emit(charset_letter(g), 1'b0);
			end
			for (int i = 0; i < 6; i++) begin
				csum = polymod_step(csum, 5'd0);
			end
			fin = csum ^ M_CONST;
			for (int i = 0; i < 6; i++) begin
				emit(charset_letter(fin[5*(5-i) +: 5]), i == 5);
			end
			csum       = 30'd1;
			spare_bits = 4'd0;
			spare_cnt  = 3'd0;
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns  MISMATCH  %s", $time, msg);
		mismatches++;
	endtask

	// ---------------------------------------------------------------------
	// Drivers. All called at a falling edge and return at a falling edge.
	// ---------------------------------------------------------------------

	// Offers one word, waits for the handshake, then books its characters.
	// Typed-in characters, where given, replace the leading predicted ones.
	task automatic send_word(input logic [7:0] b, input logic f, input logic l,
			input string known);
		while ($urandom_range(99) < src_gap_pct) begin
			byte_if.valid = 1'b0;
			@(negedge clk);
		end
		byte_if.valid        = 1'b1;
		byte_if.payload_byte = b;
		byte_if.first_byte   = f;
		byte_if.last_byte    = l;
		@(posedge clk);
		while (!byte_if.ready) begin
			@(posedge clk);
		end
		fresh_chars.delete();
		encode_word(b, f, l);
		for (int i = 0; i < known.len() && i < fresh_chars.size(); i++) begin
			fresh_chars[i].ch  = known[i][6:0];
			fresh_chars[i].fin = 1'b0;
		end
		foreach (fresh_chars[i]) begin
			chars_due.push_back(fresh_chars[i]);
		end
		words_sent++;
		if (l) strings_closed++;
		@(negedge clk);
	endtask

	// Sender pause: nothing offered until every owed character is out
	task automatic settle_idle();
		byte_if.valid = 1'b0;
		while (chars_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register write; only called with the block idle
	task automatic write_reg(input logic [b32m_pkg::CFG_IDX_W-1:0] idx,
			input logic [b32m_pkg::HRP_TEXT_W-1:0] d);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = d;
		@(posedge clk);
		while (!cfg_if.ready) begin
			@(posedge clk);
		end
		if (idx == b32m_pkg::REG_HRP_TEXT) begin
			pfx_text = d;
		end else begin
			pfx_len = d[b32m_pkg::HRP_LEN_W-1:0];
		end
		reg_writes++;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	function automatic logic [b32m_pkg::HRP_TEXT_W-1:0] lowercase_text();
		logic [b32m_pkg::HRP_TEXT_W-1:0] t;
		for (int i = 0; i < 8; i++) begin
			t[8*i +: 8] = 8'(97 + $urandom_range(25));
		end
		return t;
	endfunction

	// Mostly well-formed strings with random content; the rest are strings
	// left open (later cut short by a new first word) and loose words
	// carrying random flags. Always ends with a closing word.
	task automatic random_strings(input int quota);
		int start_cnt;
		int r;
		int n;
		start_cnt = words_sent;
		while (words_sent - start_cnt < quota) begin
			r = $urandom_range(99);
			if (r < 78) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				for (int k = 0; k < n; k++) begin
					send_word(8'($urandom_range(255)), k == 0, k == n - 1, "");
				end
			end else if (r < 90) begin
				n = $urandom_range(1, 5);
				for (int k = 0; k < n; k++) begin
					send_word(8'($urandom_range(255)), k == 0, 1'b0, "");
				end
			end else begin
				send_word(8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)), "");
			end
		end
		send_word(8'($urandom_range(255)), 1'b0, 1'b1, "");
	endtask

	// ---------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off when the stimulus asks
	// ---------------------------------------------------------------------
	initial begin
		char_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				char_if.ready = 1'b0;
				hold_left--;
			end else if (holds_served != holds_asked) begin
				holds_served++;
				hold_left     = HOLD_CYCLES - 1;
				char_if.ready = 1'b0;
			end else begin
				char_if.ready = ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Output check: each character against the oldest one owed
	always @(posedge clk) begin : char_check
		enc_char_t want;
		if (arst_n && char_if.valid && char_if.ready) begin
			chars_seen++;
			if (chars_due.size() == 0) begin
				report_mismatch($sformatf("char 0x%02h last %0d with nothing owed",
					char_if.out_char, char_if.last_char));
			end else begin
				want = chars_due.pop_front();
				if (char_if.out_char !== want.ch) begin
					report_mismatch($sformatf("char #%0d out_char 0x%02h, want 0x%02h",
						chars_seen, char_if.out_char, want.ch));
				end
				if (char_if.last_char !== want.fin) begin
					report_mismatch($sformatf("char #%0d last_char %0d, want %0d",
						chars_seen, char_if.last_char, want.fin));
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d characters still owed",
				cycle_count, chars_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	initial begin
		arst_n               = 1'b0;
		byte_if.valid        = 1'b0;
		byte_if.payload_byte = 8'd0;
		byte_if.first_byte   = 1'b0;
		byte_if.last_byte    = 1'b0;
		cfg_if.valid         = 1'b0;
		cfg_if.index         = b32m_pkg::REG_HRP_TEXT;
		cfg_if.data          = '0;

		// Directed words. Known text is only given where it is plain by hand:
		// prefix "sp" from reset, all-zero and all-one bytes, pads.
		dir_rows = '{
			// reset prefix "sp", all-zero byte opens, all-one bytes follow and close
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'h00, 1'b1, 1'b0, "sp1qq"},
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'hff, 1'b0, 1'b0, "rl"},
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'hff, 1'b0, 1'b1, "l7"},
			// first and last on one word
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'ha5, 1'b1, 1'b1, "sp1q55"},
			// words with no open string just carry on from the idle state
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'h00, 1'b0, 1'b0, "q"},
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'h08, 1'b0, 1'b1, "qyq"},
			// new first word mid-string drops the unfinished one
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'h12, 1'b1, 1'b0, "sp1q"},
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'h34, 1'b1, 1'b0, "sp1q"},
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'h56, 1'b0, 1'b1, ""},
			// zero length is taken as one character
			'{ROW_CFG,  b32m_pkg::REG_HRP_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, ""},
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'h00, 1'b1, 1'b1, "s1qqq"},
			// prefix bytes with bit 7 set, length above the maximum
			'{ROW_CFG,  b32m_pkg::REG_HRP_TEXT,   64'hffff_ffff_ffff_ffff, 8'h00, 1'b0, 1'b0, ""},
			'{ROW_CFG,  b32m_pkg::REG_HRP_LENGTH, 64'd15, 8'h00, 1'b0, 1'b0, ""},
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'hff, 1'b1, 1'b1, ""},
			'{ROW_CFG,  b32m_pkg::REG_HRP_LENGTH, 64'd8, 8'h00, 1'b0, 1'b0, ""},
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'h7f, 1'b1, 1'b0, ""},
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'h80, 1'b0, 1'b0, ""},
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'hc3, 1'b0, 1'b1, ""},
			// back to "sp", one character long
			'{ROW_CFG,  b32m_pkg::REG_HRP_TEXT,   b32m_pkg::HRP_TEXT_RST, 8'h00, 1'b0, 1'b0, ""},
			'{ROW_CFG,  b32m_pkg::REG_HRP_LENGTH, 64'd1, 8'h00, 1'b0, 1'b0, ""},
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'h01, 1'b1, 1'b0, "s1qq"},
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'h00, 1'b0, 1'b1, "yqq"},
			'{ROW_CFG,  b32m_pkg::REG_HRP_LENGTH, 64'(b32m_pkg::HRP_LEN_RST), 8'h00,
				1'b0, 1'b0, ""},
			'{ROW_WORD, b32m_pkg::REG_HRP_TEXT,   64'd0, 8'hc3, 1'b1, 1'b1, "sp1q"}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Sender idles now and then, receiver stalls most of the time
		src_gap_pct    = 13;
		sink_stall_pct = 63;
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				settle_idle();
				write_reg(dir_rows[r].idx, dir_rows[r].data);
			end else begin
				send_word(dir_rows[r].b, dir_rows[r].f, dir_rows[r].l, dir_rows[r].known);
			end
		end

		// Random phase 1: single-character prefix. Opens with a long receiver
		// hold-off so the block backs up and stalls its input.
		settle_idle();
		write_reg(b32m_pkg::REG_HRP_TEXT, lowercase_text());
		write_reg(b32m_pkg::REG_HRP_LENGTH, 64'd1);
		holds_asked++;
		random_strings(125);

		// Random phase 2: the other way round; full eight-character prefix of
		// random bits. Sender drains the block halfway through.
		settle_idle();
		src_gap_pct    = 63;
		sink_stall_pct = 13;
		write_reg(b32m_pkg::REG_HRP_TEXT, {32'($urandom), 32'($urandom)});
		write_reg(b32m_pkg::REG_HRP_LENGTH, 64'd8);
		random_strings(60);
		settle_idle();
		random_strings(60);

		// Random phase 3: no idling at all, random length including out of range
		settle_idle();
		src_gap_pct    = 0;
		sink_stall_pct = 0;
		write_reg(b32m_pkg::REG_HRP_TEXT, lowercase_text());
		write_reg(b32m_pkg::REG_HRP_LENGTH, 64'($urandom_range(15)));
		random_strings(125);

		// Let everything out, then watch a while longer for strays
		settle_idle();
		if (chars_due.size() != 0) begin
			report_mismatch($sformatf("%0d characters never came out", chars_due.size()));
		end

		$display("Covered %0d words (%0d closed strings) and %0d characters,",
			words_sent, strings_closed, chars_seen);
		$display("%0d register writes, %0d mismatches", reg_writes, mismatches);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
